FILE: src/ksc_pkg.sv
package ksc_pkg;

    // one row entry: reachable flag, least cost, distinct item count
    typedef struct packed {
        logic        valid;
        logic [31:0] cost;
        logic [7:0]  count;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    // entry for volume zero: reachable at no cost with no items
    localparam t_entry ENTRY_ZERO = '{valid: 1'b1, cost: 32'd0, count: 8'd0};

    // unreachable entry
    localparam t_entry ENTRY_NONE = '{valid: 1'b0, cost: 32'd0, count: 8'd0};

    localparam int unsigned COST_W   = 16;
    localparam int unsigned VOLUME_W = 16;
    localparam int unsigned TARGET_W = 11;

endpackage

FILE: src/ksc_row_ram.sv
module ksc_row_ram
    import ksc_pkg::*;
#(
    parameter int unsigned DEPTH = 1025,
    parameter int unsigned AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_entry        o_rdata_a,
    output t_entry        o_rdata_b
);

    t_entry r_mem [DEPTH];

    // one write port, two registered read ports, read returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: src/ksc_relax_unit.sv
module ksc_relax_unit
    import ksc_pkg::*;
(
    input  t_entry              i_base,
    input  t_entry              i_src_same,
    input  t_entry              i_src_new,
    input  logic [COST_W-1:0]   i_cost,
    output t_entry              o_entry
);

    // candidate from a source entry: saturating cost add, saturating count add
    function automatic t_entry make_cand(input t_entry src, input logic [COST_W-1:0] c,
                                         input logic inc);
        logic [32:0] sum;
        logic [8:0]  cnt;
        t_entry      res;
        sum = {1'b0, src.cost} + 33'(c);
        cnt = {1'b0, src.count} + 9'(inc);
        res.valid = src.valid;
        res.cost  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        res.count = cnt[8] ? 8'hFF : cnt[7:0];
        return res;
    endfunction

    // keep the cheaper entry, larger count on equal cost
    function automatic t_entry pick(input t_entry dst, input t_entry cand);
        t_entry res;
        res = dst;
        if (cand.valid) begin
            if (!dst.valid || cand.cost < dst.cost) begin
                res = cand;
            end else if (cand.cost == dst.cost && cand.count > dst.count) begin
                res.count = cand.count;
            end
        end
        return res;
    endfunction

    t_entry cand_same;
    t_entry cand_new;
    t_entry mid;

    // both adders work in parallel, then two compare steps
    always_comb begin
        cand_same = make_cand(i_src_same, i_cost, 1'b0);
        cand_new  = make_cand(i_src_new, i_cost, 1'b1);
        mid       = pick(i_base, cand_same);
        o_entry   = pick(mid, cand_new);
    end

endmodule

FILE: src/knapsack_min_cost_cover_unit.sv
// Minimum-cost cover of a target volume, unbounded knapsack.
// Input stream s_axis: one transaction per item, tdata = {item_volume, item_cost},
// tlast marks the last item of a set. Output stream m_axis: one transaction per
// set, tdata = {distinct_items, min_cost}. Config channel i_cfg_*: target volume.
// Each item sweeps volume indexes 1..MAX_TARGET, one index per cycle, through a
// single relax unit fed by two ping-pong row memories (one holds the previous
// row, the other receives the current row). One item occupies the block from
// the accepting cycle through the sweep and the drain of the read stage; a last
// item also holds it in the finish state until the result loads. s_axis_tready
// is low meanwhile.
// After a last item the result passes from the finish state into the output
// register once that is free; it waits there while m_axis_tready is low, and
// the next item may be accepted and swept meanwhile. A further result only
// stalls if the earlier one has still not been taken when its sweep ends.
// Reset (synchronous, active low) sets the target to 1 and starts a fresh set;
// the first item of every set treats the previous row as unreachable, so no
// memory clearing pass is needed.
module knapsack_min_cost_cover_unit
    import ksc_pkg::*;
#(
    parameter int unsigned MAX_TARGET = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,    // target_volume
    // item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // item_cost[15:0], item_volume[31:16]
    input  logic        s_axis_tlast,  // last_item
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // min_cost[31:0], distinct_items[39:32]
);

    localparam int unsigned IW    = $clog2(MAX_TARGET + 1);
    localparam int unsigned DEPTH = MAX_TARGET + 1;
    localparam int unsigned SW    = (IW > VOLUME_W) ? IW : VOLUME_W;
    localparam int unsigned CW    = (IW > TARGET_W) ? IW : TARGET_W;
    localparam logic [IW-1:0] J_LAST = IW'(MAX_TARGET);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [TARGET_W-1:0]   r_target;
    logic [IW-1:0]         r_tgt_idx;
    logic [COST_W-1:0]     r_cost;
    logic [VOLUME_W-1:0]   r_vol;
    logic                  r_vol0;
    logic                  r_last;
    logic                  r_fresh;
    logic                  r_bank;
    logic [IW-1:0]         r_j;
    logic                  r_v2;
    logic [IW-1:0]         r_j2;
    logic [IW-1:0]         r_s2;
    logic                  r_szero2;
    logic [IW-1:0]         r_last_addr;
    t_entry                r_last_data;
    t_entry                r_res;
    logic                  r_out_valid;
    logic [31:0]           r_out_cost;
    logic [7:0]            r_out_cnt;

    logic                  in_fire;
    logic                  cfg_fire;
    logic [IW-1:0]         src_idx;
    logic                  src_zero;
    logic [SW-1:0]         j_ext;
    logic [SW-1:0]         v_ext;
    logic [IW-1:0]         tgt_clamped;
    t_entry                b0_qa, b0_qb, b1_qa, b1_qb;
    t_entry                prev_qa, prev_qb, cur_qb;
    t_entry                prev_j, prev_s, cur_s;
    t_entry                relaxed;
    logic                  sweep_end;
    logic                  out_free;
    logic                  res_load;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cnt, r_out_cost};
    assign out_free      = !r_out_valid || m_axis_tready;
    assign res_load      = (r_state == S_FINISH) && out_free;
    assign sweep_end     = r_v2 && (r_j2 == J_LAST);

    // target clamp to the row length
    assign tgt_clamped = (CW'(r_target) > CW'(MAX_TARGET)) ? J_LAST : IW'(r_target);

    // source index j - volume, clamped at zero; volume zero reads index j
    always_comb begin
        j_ext = SW'(r_j);
        v_ext = SW'(r_vol);
        if (r_vol0) begin
            src_idx = r_j;
        end else if (j_ext > v_ext) begin
            src_idx = IW'(j_ext - v_ext);
        end else begin
            src_idx = '0;
        end
        src_zero = !r_vol0 && (src_idx == '0);
    end

    // ping-pong rows: r_bank selects which memory holds the previous row
    ksc_row_ram #(.DEPTH(DEPTH), .AW(IW)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (r_v2 && r_bank),
        .i_waddr   (r_j2),
        .i_wdata   (relaxed),
        .i_raddr_a (r_j),
        .i_raddr_b (src_idx),
        .o_rdata_a (b0_qa),
        .o_rdata_b (b0_qb)
    );

    ksc_row_ram #(.DEPTH(DEPTH), .AW(IW)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (r_v2 && !r_bank),
        .i_waddr   (r_j2),
        .i_wdata   (relaxed),
        .i_raddr_a (r_j),
        .i_raddr_b (src_idx),
        .o_rdata_a (b1_qa),
        .o_rdata_b (b1_qb)
    );

    // operand selection: fresh set, index zero, volume zero, write forwarding
    always_comb begin
        prev_qa = r_bank ? b1_qa : b0_qa;
        prev_qb = r_bank ? b1_qb : b0_qb;
        cur_qb  = r_bank ? b0_qb : b1_qb;
        prev_j  = r_fresh ? ENTRY_NONE : prev_qa;
        if (r_szero2) begin
            prev_s = ENTRY_ZERO;
            cur_s  = ENTRY_ZERO;
        end else begin
            prev_s = r_fresh ? ENTRY_NONE : prev_qb;
            if (r_vol0) begin
                cur_s = prev_j;
            end else if (r_s2 == r_last_addr) begin
                cur_s = r_last_data;
            end else begin
                cur_s = cur_qb;
            end
        end
    end

    ksc_relax_unit u_relax (
        .i_base     (prev_j),
        .i_src_same (cur_s),
        .i_src_new  (prev_s),
        .i_cost     (r_cost),
        .o_entry    (relaxed)
    );

    // sequencer, pipeline registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= TARGET_W'(1);
            r_fresh     <= 1'b1;
            r_bank      <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_target <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready && !res_load) begin
                r_out_valid <= 1'b0;
            end

            // read stage: one index per cycle
            r_v2     <= (r_state == S_SWEEP);
            r_j2     <= r_j;
            r_s2     <= src_idx;
            r_szero2 <= src_zero;

            // relax stage: write back, remember for forwarding, capture target
            if (r_v2) begin
                r_last_addr <= r_j2;
                r_last_data <= relaxed;
                if (r_j2 == r_tgt_idx) begin
                    r_res <= relaxed;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cost      <= s_axis_tdata[15:0];
                        r_vol       <= s_axis_tdata[31:16];
                        r_vol0      <= (s_axis_tdata[31:16] == '0);
                        r_last      <= s_axis_tlast;
                        r_tgt_idx   <= tgt_clamped;
                        r_res       <= ENTRY_ZERO;
                        r_j         <= IW'(1);
                        r_last_addr <= '0;
                        r_state     <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_j == J_LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (sweep_end) begin
                        r_bank  <= !r_bank;
                        r_fresh <= r_last;
                        r_state <= r_last ? S_FINISH : S_IDLE;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_cost  <= r_res.valid ? r_res.cost : 32'hFFFF_FFFF;
                        r_out_cnt   <= r_res.valid ? r_res.count : 8'd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the relax stage only runs while an item is being swept
    a_relax_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("relax stage active outside a sweep");

    // no item is taken while the pipeline still holds an index
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_v2)
        else $error("input ready while sweep in flight");

    // consecutive relax steps cover consecutive indexes
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && $past(r_v2)) |-> (r_j2 == $past(r_j2) + IW'(1)))
        else $error("sweep skipped or repeated an index");

    // rows swap only when a sweep completes
    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> $past(sweep_end))
        else $error("row banks swapped mid sweep");

    // a result appears only out of the finish state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_FINISH))
        else $error("result shown without a finished set");
`endif

endmodule

FILE: dv/knapsack_min_cost_cover_unit_tb.sv
module knapsack_min_cost_cover_unit_tb
    import ksc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_TARGET  = 1024;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    // sweep plus read latency plus accepting cycle, with margin
    localparam int unsigned SETTLE_CYCLES = MAX_TARGET + 76;

    // one expected cover result
    typedef struct packed {
        logic [31:0] min_cost;
        logic [7:0]  distinct;
    } t_cover;

    // predicts the cover of each set and checks the result stream
    class cover_checker;
        t_entry               prev_row [MAX_TARGET+1];
        t_entry               cur_row  [MAX_TARGET+1];
        logic [TARGET_W-1:0]  target;
        t_cover               expected_covers [$];
        int unsigned          errors;

        function new();
            target = 11'd1;
            errors = 0;
            clear_rows();
        endfunction

        function void clear_rows();
            foreach (prev_row[i]) begin
                prev_row[i] = ENTRY_NONE;
                cur_row[i]  = ENTRY_NONE;
            end
            prev_row[0] = ENTRY_ZERO;
            cur_row[0]  = ENTRY_ZERO;
        endfunction

        // offer src + cost as a candidate for dst
        function t_entry relax(t_entry dst, t_entry src, logic [15:0] c, bit bump);
            logic [32:0] sum;
            logic [8:0]  cnt;
            t_entry      cand;
            if (!src.valid)
                return dst;
            sum = {1'b0, src.cost} + 33'(c);
            cnt = {1'b0, src.count} + 9'(bump);
            cand.valid = 1'b1;
            cand.cost  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            cand.count = cnt[8] ? 8'hFF : cnt[7:0];
            if (!dst.valid || cand.cost < dst.cost)
                return cand;
            if (cand.cost == dst.cost && cand.count > dst.count)
                dst.count = cand.count;
            return dst;
        endfunction

        function void note_target(logic [TARGET_W-1:0] value);
            target = value;
        endfunction

        function int unsigned reach();
            return (target > MAX_TARGET) ? MAX_TARGET : int'(target);
        endfunction

        function int unsigned pending();
            return expected_covers.size();
        endfunction

        // sweep the row for one accepted item
        function void take_item(logic [15:0] c, logic [15:0] v, logic last);
            int unsigned src;
            t_cover      want;
            cur_row[0] = prev_row[0];
            for (int unsigned j = 1; j <= MAX_TARGET; j++) begin
                cur_row[j] = prev_row[j];
                src = (v == 0) ? j : ((j > v) ? j - v : 0);
                cur_row[j] = relax(cur_row[j], cur_row[src], c, 1'b0);
                cur_row[j] = relax(cur_row[j], prev_row[src], c, 1'b1);
            end
            prev_row = cur_row;
            if (!last)
                return;
            if (cur_row[reach()].valid) begin
                want.min_cost = cur_row[reach()].cost;
                want.distinct = cur_row[reach()].count;
            end else begin
                want.min_cost = 32'hFFFF_FFFF;
                want.distinct = 8'd0;
            end
            expected_covers.push_back(want);
            clear_rows();
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_cover(logic [39:0] data);
            t_cover want;
            if (expected_covers.size() == 0) begin
                flag_mismatch($sformatf("unexpected result cost %0d count %0d",
                                        data[31:0], data[39:32]));
            end else begin
                want = expected_covers.pop_front();
                if (data[31:0] !== want.min_cost)
                    flag_mismatch($sformatf("min_cost %0h, want %0h",
                                            data[31:0], want.min_cost));
                if (data[39:32] !== want.distinct)
                    flag_mismatch($sformatf("distinct_items %0d, want %0d",
                                            data[39:32], want.distinct));
            end
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // item_cost[15:0], item_volume[31:16]
    logic        s_axis_tlast  = 1'b0; // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // min_cost[31:0], distinct_items[39:32]

    cover_checker chk;
    bit           calm;
    int unsigned  stall_left;
    int unsigned  cycles;

    knapsack_min_cost_cover_unit #(
        .MAX_TARGET(MAX_TARGET)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure
    function automatic int unsigned result_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(10, 80);
        return $urandom_range(900, 2500);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end else if (!calm && $urandom_range(0, 99) == 0) begin
            stall_left    = result_stall() - 1;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // result transaction check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_cover(m_axis_tdata);
    end

    function automatic int unsigned item_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(10, 60);
        return $urandom_range(1000, 2000);
    endfunction

    // one item transaction; tvalid stays high until the next call or stop_items
    task automatic send_item(logic [15:0] c, logic [15:0] v, logic last);
        int unsigned gap;
        gap = item_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {v, c};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        chk.take_item(c, v, last);
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // target write once the block has drained and finished its sweep
    task automatic write_target(logic [10:0] value);
        stop_items();
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.note_target(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [10:0] pick_target();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 11'($urandom_range(1, 40));
        if (r < 80)
            return 11'($urandom_range(41, 300));
        if (r < 90)
            return 11'($urandom_range(1024, 2047));
        if (r < 95)
            return 11'd0;
        return 11'($urandom_range(301, 1023));
    endfunction

    // item with content biased toward ties and reachable targets
    task automatic random_item(output logic [15:0] c, output logic [15:0] v);
        int unsigned r;
        int unsigned span;
        span = (chk.reach() == 0) ? 1 : chk.reach();
        r = $urandom_range(0, 99);
        if (r < 50)
            c = 16'($urandom_range(0, 7));
        else if (r < 80)
            c = 16'($urandom_range(0, 255));
        else
            c = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 8)
            v = 16'd0;
        else if (r < 70)
            v = 16'($urandom_range(1, span));
        else if (r < 85)
            v = 16'($urandom_range(span, span + 50));
        else
            v = 16'($urandom_range(0, 65535));
    endtask

    initial begin
        int          budget;
        int          set_len;
        int          n;
        int unsigned phase;
        logic [15:0] c;
        logic [15:0] v;

        chk = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset target, free item, widest fields
        send_item(16'd0, 16'd1, 1'b1);
        send_item(16'hFFFF, 16'hFFFF, 1'b1);
        // target zero
        write_target(11'd0);
        send_item(16'd5, 16'd3, 1'b1);
        // target past the row, uncovered then covered sets, zero volume
        write_target(11'h7FF);
        send_item(16'd7, 16'd0, 1'b1);
        send_item(16'd3, 16'd512, 1'b0);
        send_item(16'd2, 16'd300, 1'b0);
        send_item(16'hFFFF, 16'd0, 1'b0);
        send_item(16'hFFFF, 16'hFFFF, 1'b1);
        // full row, equal-cost ties
        write_target(11'd1024);
        send_item(16'd0, 16'd0, 1'b0);
        send_item(16'd10, 16'd1024, 1'b0);
        send_item(16'd9, 16'd1023, 1'b0);
        send_item(16'd10, 16'd1024, 1'b1);
        // target changed in the middle of a set
        write_target(11'd100);
        send_item(16'd4, 16'd7, 1'b0);
        write_target(11'd1);
        send_item(16'd1, 16'd1, 1'b1);
        // small cover with ties between item mixes
        write_target(11'd3);
        send_item(16'd2, 16'd1, 1'b0);
        send_item(16'd2, 16'd1, 1'b0);
        send_item(16'd6, 16'd3, 1'b1);

        // random sets, one long set drives the distinct count to saturation
        budget = 560;
        phase  = 0;
        while (budget > 0) begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                write_target(11'($urandom_range(1, 8)));
                send_item(16'($urandom_range(0, 3)), 16'd1, 1'b0);
                set_len = $urandom_range(258, 266);
                for (int k = 0; k < set_len; k++) begin
                    if ($urandom_range(0, 9) != 0) begin
                        c = 16'd0;
                        v = 16'd0;
                    end else begin
                        random_item(c, v);
                    end
                    send_item(c, v, k == set_len - 1);
                end
                budget -= set_len + 1;
            end else begin
                write_target(pick_target());
                n = 0;
                while (n < 30 && budget > 0) begin
                    set_len = ($urandom_range(0, 9) < 4) ? 1 : $urandom_range(2, 6);
                    for (int k = 0; k < set_len; k++) begin
                        random_item(c, v);
                        send_item(c, v, k == set_len - 1);
                    end
                    n      += set_len;
                    budget -= set_len;
                end
            end
            phase++;
        end

        // drain
        stop_items();
        calm = 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
